/* src/hsv_to_rgb_pixel_top_defines.svh */
// Assertion macros for the HSV to RGB pixel RTL.
`ifndef HSV_TO_RGB_PIXEL_TOP_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HSVRGB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define HSVRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/hsvrgb_pkg.sv */
// Package with word types and hue region codes for the HSV to RGB pixel block.
package hsvrgb_pkg;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } in_word_t;

  typedef struct packed {
    logic [7:0] white_level;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } out_word_t;

  // Sixths of the hue circle
  typedef enum logic [2:0] {
    REGION_RED_YELLOW    = 3'd0,
    REGION_YELLOW_GREEN  = 3'd1,
    REGION_GREEN_CYAN    = 3'd2,
    REGION_CYAN_BLUE     = 3'd3,
    REGION_BLUE_MAGENTA  = 3'd4,
    REGION_MAGENTA_RED   = 3'd5
  } region_t;

  localparam logic [7:0] LEVEL_MAX = 8'd255;

endpackage

/* src/hsv_to_rgb_pixel_top.sv */
// HSV to RGB/RGBW pixel converter, four-stage pipeline.
//
// Input channel in_valid / in_stall / in_word carries one hue, saturation and
// brightness word; a word is taken at a rising edge with in_valid high and
// in_stall low. The result channel out_valid / out_stall / out_word carries one
// white, red, green and blue word per input word, in order.
// The accepting edge loads stage one; the word then passes stage two, stage
// three and the output register, where out_valid rises (hue split; three 8x8
// products; complement; then two 8x8 products with region routing into the output register).
// Throughput is one word per clock while out_stall is low; each stage holds its own valid bit, so
// bubbles close up and new words are taken while a finished result still waits
// at the output.
// When out_stall is high the output word holds, and the stages behind it fill
// up; in_stall rises only once every stage holds a word.
// cfg_we / cfg_wdata write the white channel mode bit (1: zero saturation
// drives white only). Write it only while the pipeline is empty.
// rst_n (synchronous, active low) empties the pipeline and clears the mode bit.
module hsv_to_rgb_pixel_top
  import hsvrgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

`include "hsv_to_rgb_pixel_top_defines.svh"

  logic white_mode_r;

  // stage 1: hue split
  logic        s1_valid_r;
  region_t     s1_region_r;
  logic [7:0]  s1_rem_r;
  logic [7:0]  s1_sat_r;
  logic [7:0]  s1_bri_r;
  logic        s1_grey_r;

  // stage 2: first products
  logic        s2_valid_r;
  region_t     s2_region_r;
  logic [15:0] s2_prod_q_r;
  logic [15:0] s2_prod_t_r;
  logic [15:0] s2_prod_p_r;
  logic [7:0]  s2_bri_r;
  logic        s2_grey_r;

  // stage 3: shade factors
  logic        s3_valid_r;
  region_t     s3_region_r;
  logic [7:0]  s3_fq_r;
  logic [7:0]  s3_ft_r;
  logic [7:0]  s3_p_r;
  logic [7:0]  s3_bri_r;
  logic        s3_grey_r;

  // stage 4: output register
  logic        out_valid_r;
  out_word_t   out_word_r;

  logic rdy1, rdy2, rdy3, rdy4;

  logic [10:0] h6_nxt;
  logic [15:0] q_full, t_full;
  logic [7:0]  q_lvl, t_lvl;
  out_word_t   out_word_nxt;

  // Advance a stage when it is empty or the one after it advances
  assign rdy4 = !out_valid_r || !out_stall;
  assign rdy3 = !s3_valid_r || rdy4;
  assign rdy2 = !s2_valid_r || rdy3;
  assign rdy1 = !s1_valid_r || rdy2;

  assign in_stall  = !rdy1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_mode_r <= 1'b0;
    end else if (cfg_we) begin
      white_mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r  <= in_valid;
      if (rdy2) s2_valid_r  <= s1_valid_r;
      if (rdy3) s3_valid_r  <= s2_valid_r;
      if (rdy4) out_valid_r <= s3_valid_r;
    end
  end

  assign h6_nxt = 11'(in_word.hue) * 11'd6;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_region_r <= region_t'(h6_nxt[10:8]);
      s1_rem_r    <= h6_nxt[7:0];
      s1_sat_r    <= in_word.saturation;
      s1_bri_r    <= in_word.brightness;
      s1_grey_r   <= (in_word.saturation == 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid_r) begin
      s2_region_r <= s1_region_r;
      s2_prod_q_r <= 16'(s1_sat_r) * 16'(s1_rem_r);
      s2_prod_t_r <= 16'(s1_sat_r) * 16'(LEVEL_MAX - s1_rem_r);
      s2_prod_p_r <= 16'(s1_bri_r) * 16'(LEVEL_MAX - s1_sat_r);
      s2_bri_r    <= s1_bri_r;
      s2_grey_r   <= s1_grey_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_valid_r) begin
      s3_region_r <= s2_region_r;
      s3_fq_r     <= LEVEL_MAX - s2_prod_q_r[15:8];
      s3_ft_r     <= LEVEL_MAX - s2_prod_t_r[15:8];
      s3_p_r      <= s2_prod_p_r[15:8];
      s3_bri_r    <= s2_bri_r;
      s3_grey_r   <= s2_grey_r;
    end
  end

  assign q_full = 16'(s3_bri_r) * 16'(s3_fq_r);
  assign t_full = 16'(s3_bri_r) * 16'(s3_ft_r);
  assign q_lvl  = q_full[15:8];
  assign t_lvl  = t_full[15:8];

  always_comb begin
    out_word_nxt = '0;
    if (s3_grey_r) begin
      if (white_mode_r) begin
        out_word_nxt.white_level = s3_bri_r;
      end else begin
        out_word_nxt.red_level   = s3_bri_r;
        out_word_nxt.green_level = s3_bri_r;
        out_word_nxt.blue_level  = s3_bri_r;
      end
    end else begin
      unique case (s3_region_r)
        REGION_RED_YELLOW: begin
          out_word_nxt.red_level   = s3_bri_r;
          out_word_nxt.green_level = t_lvl;
          out_word_nxt.blue_level  = s3_p_r;
        end
        REGION_YELLOW_GREEN: begin
          out_word_nxt.red_level   = q_lvl;
          out_word_nxt.green_level = s3_bri_r;
          out_word_nxt.blue_level  = s3_p_r;
        end
        REGION_GREEN_CYAN: begin
          out_word_nxt.red_level   = s3_p_r;
          out_word_nxt.green_level = s3_bri_r;
          out_word_nxt.blue_level  = t_lvl;
        end
        REGION_CYAN_BLUE: begin
          out_word_nxt.red_level   = s3_p_r;
          out_word_nxt.green_level = q_lvl;
          out_word_nxt.blue_level  = s3_bri_r;
        end
        REGION_BLUE_MAGENTA: begin
          out_word_nxt.red_level   = t_lvl;
          out_word_nxt.green_level = s3_p_r;
          out_word_nxt.blue_level  = s3_bri_r;
        end
        default: begin
          out_word_nxt.red_level   = s3_bri_r;
          out_word_nxt.green_level = s3_p_r;
          out_word_nxt.blue_level  = q_lvl;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && s3_valid_r) begin
      out_word_r <= out_word_nxt;
    end
  end

  `HSVRGB_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, s1_valid_r,
                      "accepted word did not reach stage one")
  `HSVRGB_ASSERT_NEXT(a_s3_held_on_stall, s3_valid_r && !rdy4, s3_valid_r,
                      "stage three word dropped while output stalled")
  `HSVRGB_ASSERT_NOW(a_white_excludes_rgb,
                     out_valid_r && (out_word_r.white_level != 8'd0),
                     (out_word_r.red_level == 8'd0) && (out_word_r.green_level == 8'd0)
                     && (out_word_r.blue_level == 8'd0),
                     "white level driven together with colour levels")

endmodule

/* sim/hsv_rgb_checker.sv */
// Checker for the HSV to RGB pixel block: predicts each colour word and compares results.
`timescale 1ns / 100ps

module hsv_rgb_checker
  import hsvrgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  output int        fail_count,
  output int        pending,
  output int        colours_checked
);

  out_word_t colour_q[$];
  out_word_t want;
  logic      white_mode;

  // v * (255 - s*frac/256) / 256, truncated at both divides
  function automatic logic [7:0] shade_level(input logic [7:0] v, input logic [7:0] s,
                                             input logic [7:0] frac);
    logic [15:0] dim;
    logic [15:0] prod;
    dim  = {8'd0, s} * {8'd0, frac};
    prod = {8'd0, v} * {8'd0, LEVEL_MAX - dim[15:8]};
    return prod[15:8];
  endfunction

  function automatic out_word_t predict_colour(input in_word_t px, input logic white_on);
    logic [10:0] hue6;
    region_t     region;
    logic [7:0]  frac;
    logic [7:0]  v;
    logic [7:0]  p;
    logic [7:0]  q;
    logic [7:0]  t;
    logic [15:0] prod;
    out_word_t   c;
    hue6   = {3'd0, px.hue} * 11'd6;
    region = region_t'(hue6[10:8]);
    frac   = hue6[7:0];
    v      = px.brightness;
    c      = '0;
    if (px.saturation == 8'd0) begin
      if (white_on) begin
        c.white_level = v;
      end else begin
        c.red_level   = v;
        c.green_level = v;
        c.blue_level  = v;
      end
    end else begin
      prod = {8'd0, v} * {8'd0, LEVEL_MAX - px.saturation};
      p    = prod[15:8];
      q    = shade_level(v, px.saturation, frac);
      t    = shade_level(v, px.saturation, LEVEL_MAX - frac);
      case (region)
        REGION_RED_YELLOW:   {c.red_level, c.green_level, c.blue_level} = {v, t, p};
        REGION_YELLOW_GREEN: {c.red_level, c.green_level, c.blue_level} = {q, v, p};
        REGION_GREEN_CYAN:   {c.red_level, c.green_level, c.blue_level} = {p, v, t};
        REGION_CYAN_BLUE:    {c.red_level, c.green_level, c.blue_level} = {p, q, v};
        REGION_BLUE_MAGENTA: {c.red_level, c.green_level, c.blue_level} = {t, p, v};
        default:             {c.red_level, c.green_level, c.blue_level} = {v, p, q};
      endcase
    end
    return c;
  endfunction

  task automatic report_fault(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      colour_q.delete();
      white_mode      = 1'b0;
      pending         = 0;
      fail_count      = 0;
      colours_checked = 0;
    end else begin
      // retire the oldest prediction before queuing a new one
      if (out_valid && !out_stall) begin
        if (colour_q.size() == 0) begin
          report_fault($sformatf("result word %h with nothing expected", out_word));
        end else begin
          want = colour_q.pop_front();
          if (out_word.white_level !== want.white_level)
            report_fault($sformatf("white got %0d want %0d", out_word.white_level,
                                   want.white_level));
          if (out_word.red_level !== want.red_level)
            report_fault($sformatf("red got %0d want %0d", out_word.red_level,
                                   want.red_level));
          if (out_word.green_level !== want.green_level)
            report_fault($sformatf("green got %0d want %0d", out_word.green_level,
                                   want.green_level));
          if (out_word.blue_level !== want.blue_level)
            report_fault($sformatf("blue got %0d want %0d", out_word.blue_level,
                                   want.blue_level));
          colours_checked++;
        end
      end
      if (in_valid && !in_stall)
        colour_q.push_back(predict_colour(in_word, white_mode));
      if (cfg_we)
        white_mode = cfg_wdata;
      pending = colour_q.size();
    end
  end

endmodule

/* sim/testbench.sv */
// Top of the HSV to RGB pixel testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import hsvrgb_pkg::*;

  localparam int PIPE_LATENCY = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_we;
  logic      cfg_wdata;

  int fail_count;
  int pending;
  int colours_checked;
  int words_sent;
  int cycle_count;
  int burst_left;
  bit hold_request;
  bit quiet_tail;

  // hue, saturation, brightness: region edges, grey and white, dark and faint
  logic [23:0] corner_words [0:19] = '{
    24'h00FFFF, 24'h2AFFFF, 24'h2BFFFF, 24'h55FFFF, 24'h56FFFF,
    24'h7FFFFF, 24'h80FFFF, 24'hAAFFFF, 24'hABFFFF, 24'hD5FFFF,
    24'hD6FFFF, 24'hFFFFFF, 24'h6400FF, 24'hC80000, 24'h1E0080,
    24'h3C01FF, 24'h96FF00, 24'hF0FF01, 24'hFF01FF, 24'h0000FF
  };

  always #5 clk = ~clk;

  hsv_to_rgb_pixel_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  hsv_rgb_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_word         (in_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word        (out_word),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .colours_checked (colours_checked)
  );

  // hold the word until it is taken
  task automatic send_pixel(input in_word_t px);
    in_valid <= 1'b1;
    in_word  <= px;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic set_white_mode(input logic mode);
    in_valid <= 1'b0;
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_corners();
    for (int i = 0; i < 20; i++)
      send_pixel(in_word_t'(corner_words[i]));
  endtask

  task automatic run_random(input int count, input int hold_at);
    in_word_t px;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) begin
        hold_request = 1'b1;
        burst_left   = 40;
      end
      px.hue        = 8'($urandom);
      px.saturation = 8'($urandom);
      px.brightness = 8'($urandom);
      case ($urandom_range(0, 7))
        0: px.saturation = 8'd0;
        1: px.saturation = LEVEL_MAX;
        2: px.brightness = ($urandom_range(0, 1) == 0) ? 8'd0 : LEVEL_MAX;
        default: ;
      endcase
      send_pixel(px);
      if (burst_left > 0) begin
        burst_left--;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("hsv_to_rgb_pixel_top test failed");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request, none in the tail
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int total_fail;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    words_sent   = 0;
    burst_left   = 0;
    hold_request = 1'b0;
    quiet_tail   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_white_mode(1'b0);
    run_corners();
    run_random(400, -1);

    set_white_mode(1'b1);
    run_corners();
    run_random(400, 150);

    set_white_mode(1'b0);
    run_random(250, -1);
    quiet_tail = 1'b1;
    run_random(150, -1);

    in_valid <= 1'b0;
    wait_idle();
    repeat (PIPE_LATENCY * 2) @(posedge clk);

    total_fail = fail_count;
    if (pending != 0) begin
      $display("%0d predicted colours never arrived", pending);
      total_fail++;
    end
    $display("Sent %0d pixel words and checked %0d colours in RGB and RGBW modes,",
             words_sent, colours_checked);
    $display("with random idling on both sides and one %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (total_fail == 0)
      $display("hsv_to_rgb_pixel_top test passed");
    else
      $display("hsv_to_rgb_pixel_top test failed");
    $finish;
  end

endmodule
